### rtl/core/rgberle_pkg.sv
`default_nettype none
package rgberle_pkg;

	// command kinds passed from front to back
	typedef enum logic [1:0] {
		CMD_STORE  = 2'd0,
		CMD_PIXELS = 2'd1,
		CMD_ERROR  = 2'd2
	} cmd_kind_t;

	// configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [7:0] RUN_BASE  = 8'd128;
	localparam logic [7:0] RLE_MAGIC = 8'd2;
	localparam logic [8:0] EXP_BIAS  = 9'd9;    // 128 + 8 folded with the mantissa scaling
	localparam logic [8:0] NORM_MIN  = 9'd10;

	localparam logic [1:0] PLANE_RED   = 2'd0;
	localparam logic [1:0] PLANE_GREEN = 2'd1;
	localparam logic [1:0] PLANE_BLUE  = 2'd2;
	localparam logic [1:0] PLANE_EXP   = 2'd3;

	// m * 2^(e-136) as an exact single precision pattern, zero when m or e is 0
	function automatic logic [31:0] rgbe_to_float(input logic [7:0] m, input logic [7:0] e);
		logic [2:0]  p;
		logic [8:0]  s;
		logic [31:0] mw;
		logic [31:0] r;
		p  = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (m[i]) p = 3'(i);
		end
		s  = {6'd0, p} + {1'b0, e};
		mw = {24'd0, m};
		r  = 32'd0;
		if (m == 8'd0 || e == 8'd0) begin
			r = 32'd0;
		end else if (s >= NORM_MIN) begin
			mw = mw << (5'd23 - {2'd0, p});
			r  = {1'b0, 8'(s - EXP_BIAS), mw[22:0]};
		end else begin
			r = mw << (e[4:0] + 5'd13);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/rgbe_rle_scanline_decoder_top.sv
// RGBE scanline decoder (Radiance new-style RLE and flat lines).
// Input channel: one data_byte per beat (in_valid / in_stall), starting at
// the first scanline byte after the text header.
// Output channel: one result beat (out_valid / out_stall) carrying up to two
// pixels as IEEE single patterns r*2^(e-136), plus column, row_end, image_end,
// and overrun_error on an error-only beat. last_of_item marks the final beat
// caused by one input byte.
// Config: cfg_we / cfg_index / cfg_data; index 0 image_width, 1 image_height.
// Write only while the block is idle.
// Timing: the front classifies one byte per cycle while in_stall is low and
// pushes any resulting command into a 4-deep queue; a flat line header holds
// in_stall while it pushes the green, blue and pixel 0 commands. The back pops
// a command from its idle state, then does one store write per cycle on a
// color plane, or a line store read and then a convert for each pixel.
// A pixel byte reaches the output register via the queue, B_READ and B_CAPT.
// Reset: all line state cleared, width 4096, height 1; line store contents
// are undefined until written, no clearing pass.
// A stalled receiver holds the output register; the back and then the queue
// fill, and in_stall rises once the queue is full.
`default_nettype none
module rgbe_rle_scanline_decoder_top #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      first_red,
	output logic [31:0]      first_green,
	output logic [31:0]      first_blue,
	output logic [31:0]      second_red,
	output logic [31:0]      second_green,
	output logic [31:0]      second_blue,
	output logic [1:0]       pixel_count,
	output logic [11:0]      column,
	output logic             row_end,
	output logic             image_end,
	output logic             overrun_error,
	output logic             last_of_item
);
	import rgberle_pkg::*;

	// position must hold the width itself; address covers one plane
	localparam int PW = $clog2(MAX_WIDTH + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = 2 + 2 + PW + 7 + 8 + 3;

	logic [12:0]   width_q;
	logic [15:0]   height_q;
	logic          push, pop, full, empty;
	logic [CW-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd4096;
			height_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[12:0];
				CFG_HEIGHT: height_q <= cfg_data;
				default:    height_q <= height_q;
			endcase
		end
	end

	rgberle_front #(.MAX_WIDTH(MAX_WIDTH), .PW(PW), .CW(CW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.img_width  (width_q),
		.img_height (height_q),
		.cmd_push   (push),
		.cmd_data   (push_data),
		.cmd_full   (full)
	);

	rgberle_cmd_fifo #(.W(CW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	rgberle_back #(.MAX_WIDTH(MAX_WIDTH), .PW(PW), .AW(AW), .CW(CW)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_empty     (empty),
		.cmd_data      (pop_data),
		.cmd_pop       (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.first_red     (first_red),
		.first_green   (first_green),
		.first_blue    (first_blue),
		.second_red    (second_red),
		.second_green  (second_green),
		.second_blue   (second_blue),
		.pixel_count   (pixel_count),
		.column        (column),
		.row_end       (row_end),
		.image_end     (image_end),
		.overrun_error (overrun_error),
		.last_of_item  (last_of_item)
	);
endmodule
`default_nettype wire

### rtl/core/rgberle_cmd_fifo.sv
`default_nettype none
module rgberle_cmd_fifo #(
	parameter int W = 40
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              empty
);
	import rgberle_pkg::*;

	logic [W-1:0] slot_q [4];
	logic [1:0]   wptr_q, rptr_q;
	logic [2:0]   cnt_q;
	logic         do_push, do_pop;

	assign full     = (cnt_q == 3'd4);
	assign empty    = (cnt_q == 3'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 2'd0;
			rptr_q <= 2'd0;
			cnt_q  <= 3'd0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 2'd1;
			if (do_pop) rptr_q <= rptr_q + 2'd1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/core/rgberle_front.sv
`default_nettype none
module rgberle_front #(
	parameter int MAX_WIDTH = 4096,
	parameter int PW        = 13,
	parameter int CW        = 36
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    data_byte,
	input  wire logic [12:0]   img_width,
	input  wire logic [15:0]   img_height,
	output logic               cmd_push,
	output logic [CW-1:0]      cmd_data,
	input  wire logic          cmd_full
);
	import rgberle_pkg::*;

	localparam int XW = PW + 9;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [1:0]  plane;
		logic [PW-1:0] pos;
		logic [6:0]  cnt;
		logic [7:0]  value;
		logic        row_end;
		logic        img_end;
		logic        last;
	} cmd_t;

	typedef enum logic [2:0] {
		M_HEADER = 3'b001,
		M_RLE    = 3'b010,
		M_FLAT   = 3'b100
	} mode_t;

	mode_t        mode_q, mode_d;
	logic [7:0]   hdr_q [4];
	logic [1:0]   hcnt_q, hcnt_d;
	logic [1:0]   plane_q, plane_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [7:0]   lit_q, lit_d;
	logic [7:0]   run_q, run_d;
	logic [1:0]   phase_q, phase_d;
	logic [15:0]  row_q, row_d;
	logic [1:0]   seq_q, seq_d;
	logic         seq_re_q, seq_ie_q, seq_re_d, seq_ie_d;

	logic [15:0]  w16;
	logic [PW-1:0] w;
	logic [15:0]  h_eff;
	logic         row_last;
	logic [XW-1:0] room, cnt_x, n_x, b_x;
	logic         accept;
	logic         nl;
	cmd_t         cmd;
	logic         push_d;

	always_comb begin
		w16 = (img_width == 13'd0) ? 16'd1 : {3'd0, img_width};
		if (w16 > 16'(MAX_WIDTH)) w16 = 16'(MAX_WIDTH);
		w = w16[PW-1:0];
	end

	assign h_eff    = (img_height == 16'd0) ? 16'd1 : img_height;
	assign row_last = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
	assign room     = (pos_q < w) ? XW'(w - pos_q) : '0;
	assign cnt_x    = XW'(run_q);
	assign b_x      = XW'(data_byte);
	assign n_x      = (cnt_x < room) ? cnt_x : room;

	assign in_stall = cmd_full || (seq_q != 2'd0);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		mode_d   = mode_q;
		hcnt_d   = hcnt_q;
		plane_d  = plane_q;
		pos_d    = pos_q;
		lit_d    = lit_q;
		run_d    = run_q;
		phase_d  = phase_q;
		row_d    = row_q;
		seq_d    = seq_q;
		seq_re_d = seq_re_q;
		seq_ie_d = seq_ie_q;
		nl       = 1'b0;
		push_d   = 1'b0;
		cmd      = '{kind: CMD_STORE, plane: plane_q, pos: pos_q, cnt: 7'd1,
		             value: data_byte, row_end: 1'b0, img_end: 1'b0, last: 1'b0};

		if (seq_q != 2'd0) begin
			// flat line header: finish green, blue and pixel 0
			if (!cmd_full) begin
				push_d = 1'b1;
				seq_d  = seq_q - 2'd1;
				cmd.pos = '0;
				case (seq_q)
					2'd3: begin
						cmd.plane = PLANE_GREEN;
						cmd.value = hdr_q[1];
					end
					2'd2: begin
						cmd.plane = PLANE_BLUE;
						cmd.value = hdr_q[2];
					end
					default: begin
						cmd.kind    = CMD_PIXELS;
						cmd.plane   = PLANE_EXP;
						cmd.value   = hdr_q[3];
						cmd.row_end = seq_re_q;
						cmd.img_end = seq_ie_q;
						cmd.last    = 1'b1;
					end
				endcase
			end
		end else if (accept) begin
			case (mode_q)
				M_RLE: begin
					if (run_q != 8'd0) begin
						run_d = 8'd0;
						if (n_x != '0) begin
							push_d    = 1'b1;
							cmd.cnt   = 7'(n_x);
							cmd.kind  = (plane_q == PLANE_EXP) ? CMD_PIXELS : CMD_STORE;
							cmd.row_end = (cnt_x >= room);
							cmd.img_end = (cnt_x >= room) && row_last;
							cmd.last  = 1'b1;
							pos_d     = pos_q + PW'(n_x);
						end
					end else if (lit_q != 8'd0) begin
						lit_d = lit_q - 8'd1;
						if (pos_q < w) begin
							push_d      = 1'b1;
							cmd.kind    = (plane_q == PLANE_EXP) ? CMD_PIXELS : CMD_STORE;
							cmd.row_end = (room == XW'(1));
							cmd.img_end = (room == XW'(1)) && row_last;
							cmd.last    = 1'b1;
							pos_d       = pos_q + PW'(1);
						end
					end else if (data_byte > RUN_BASE) begin
						run_d = data_byte - RUN_BASE;
						if (XW'(data_byte - RUN_BASE) > room) begin
							push_d   = 1'b1;
							cmd.kind = CMD_ERROR;
							cmd.last = 1'b1;
						end
					end else begin
						lit_d = data_byte;
						if (b_x > room) begin
							push_d   = 1'b1;
							cmd.kind = CMD_ERROR;
							cmd.last = 1'b1;
						end
					end
					if (pos_d >= w && lit_d == 8'd0 && run_d == 8'd0) begin
						if (plane_q == PLANE_EXP) begin
							nl = 1'b1;
						end else begin
							plane_d = plane_q + 2'd1;
							pos_d   = '0;
						end
					end
				end
				M_FLAT: begin
					if (phase_q != 2'd3) begin
						phase_d = phase_q + 2'd1;
						if (pos_q < w) begin
							push_d    = 1'b1;
							cmd.plane = phase_q;
						end
					end else begin
						phase_d = 2'd0;
						if (pos_q < w) begin
							push_d      = 1'b1;
							cmd.kind    = CMD_PIXELS;
							cmd.row_end = (room == XW'(1));
							cmd.img_end = (room == XW'(1)) && row_last;
							cmd.last    = 1'b1;
						end
						pos_d = pos_q + PW'(1);
						if (pos_d >= w) nl = 1'b1;
					end
				end
				default: begin
					hcnt_d = hcnt_q + 2'd1;
					if (hcnt_q == 2'd3) begin
						hcnt_d  = 2'd0;
						plane_d = 2'd0;
						pos_d   = '0;
						lit_d   = 8'd0;
						run_d   = 8'd0;
						phase_d = 2'd0;
						if (hdr_q[0] == RLE_MAGIC && hdr_q[1] == RLE_MAGIC &&
						    {hdr_q[2], data_byte} == w16) begin
							mode_d = M_RLE;
						end else begin
							mode_d    = M_FLAT;
							push_d    = 1'b1;
							cmd.plane = PLANE_RED;
							cmd.pos   = '0;
							cmd.value = hdr_q[0];
							seq_d     = 2'd3;
							seq_re_d  = (w == PW'(1));
							seq_ie_d  = (w == PW'(1)) && row_last;
							pos_d     = PW'(1);
							if (w == PW'(1)) nl = 1'b1;
						end
					end
				end
			endcase
			if (nl) begin
				row_d   = row_last ? 16'd0 : row_q + 16'd1;
				mode_d  = M_HEADER;
				hcnt_d  = 2'd0;
				plane_d = 2'd0;
				pos_d   = '0;
				lit_d   = 8'd0;
				run_d   = 8'd0;
				phase_d = 2'd0;
			end
		end
	end

	assign cmd_push = push_d;
	assign cmd_data = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_HEADER;
			hcnt_q   <= 2'd0;
			plane_q  <= 2'd0;
			pos_q    <= '0;
			lit_q    <= 8'd0;
			run_q    <= 8'd0;
			phase_q  <= 2'd0;
			row_q    <= 16'd0;
			seq_q    <= 2'd0;
			seq_re_q <= 1'b0;
			seq_ie_q <= 1'b0;
			for (int i = 0; i < 4; i++) hdr_q[i] <= 8'd0;
		end else begin
			mode_q   <= mode_d;
			hcnt_q   <= hcnt_d;
			plane_q  <= plane_d;
			pos_q    <= pos_d;
			lit_q    <= lit_d;
			run_q    <= run_d;
			phase_q  <= phase_d;
			row_q    <= row_d;
			seq_q    <= seq_d;
			seq_re_q <= seq_re_d;
			seq_ie_q <= seq_ie_d;
			if (accept && mode_q == M_HEADER) hdr_q[hcnt_q] <= data_byte;
		end
	end
endmodule
`default_nettype wire

### rtl/core/rgberle_back.sv
`default_nettype none
module rgberle_back #(
	parameter int MAX_WIDTH = 4096,
	parameter int PW        = 13,
	parameter int AW        = 12,
	parameter int CW        = 36
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_empty,
	input  wire logic [CW-1:0] cmd_data,
	output logic             cmd_pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      first_red,
	output logic [31:0]      first_green,
	output logic [31:0]      first_blue,
	output logic [31:0]      second_red,
	output logic [31:0]      second_green,
	output logic [31:0]      second_blue,
	output logic [1:0]       pixel_count,
	output logic [11:0]      column,
	output logic             row_end,
	output logic             image_end,
	output logic             overrun_error,
	output logic             last_of_item
);
	import rgberle_pkg::*;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [1:0]  plane;
		logic [PW-1:0] pos;
		logic [6:0]  cnt;
		logic [7:0]  value;
		logic        row_end;
		logic        img_end;
		logic        last;
	} cmd_t;

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_STORE = 5'b00010,
		B_READ  = 5'b00100,
		B_CAPT  = 5'b01000,
		B_ERR   = 5'b10000
	} bstate_t;

	bstate_t       state_q;
	cmd_t          cur_q, nxt;
	logic [PW-1:0] pos_q;
	logic [6:0]    k_q;
	logic          pack_q;
	logic [31:0]   pk_r_q, pk_g_q, pk_b_q;
	logic [11:0]   pk_col_q;

	logic [7:0]    mem_r [MAX_WIDTH];
	logic [7:0]    mem_g [MAX_WIDTH];
	logic [7:0]    mem_b [MAX_WIDTH];
	logic [7:0]    rd_r_q, rd_g_q, rd_b_q;

	logic [AW-1:0] addr;
	logic          wr_en, rd_en;
	logic [31:0]   cv_r, cv_g, cv_b;
	logic          is_last, out_free, emit, out_set;
	logic [15:0]   pos16;

	assign nxt      = cmd_data;
	assign cmd_pop  = (state_q == B_IDLE) && !cmd_empty;
	assign addr     = pos_q[AW-1:0];
	assign wr_en    = (state_q == B_STORE);
	assign rd_en    = (state_q == B_READ);
	assign cv_r     = rgbe_to_float(rd_r_q, cur_q.value);
	assign cv_g     = rgbe_to_float(rd_g_q, cur_q.value);
	assign cv_b     = rgbe_to_float(rd_b_q, cur_q.value);
	assign is_last  = ((k_q + 7'd1) == cur_q.cnt);
	assign out_free = !out_valid || !out_stall;
	assign emit     = (state_q == B_CAPT) && (pack_q || is_last) && out_free;
	assign out_set  = emit || ((state_q == B_ERR) && out_free);
	assign pos16    = 16'(pos_q);

	// line store, one plane per array
	always_ff @(posedge clk) begin
		if (wr_en && cur_q.plane == PLANE_RED) mem_r[addr] <= cur_q.value;
		if (wr_en && cur_q.plane == PLANE_GREEN) mem_g[addr] <= cur_q.value;
		if (wr_en && cur_q.plane == PLANE_BLUE) mem_b[addr] <= cur_q.value;
		if (rd_en) begin
			rd_r_q <= mem_r[addr];
			rd_g_q <= mem_g[addr];
			rd_b_q <= mem_b[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			pack_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_set) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					pack_q <= 1'b0;
					if (!cmd_empty) begin
						case (nxt.kind)
							CMD_STORE:  state_q <= B_STORE;
							CMD_PIXELS: state_q <= B_READ;
							default:    state_q <= B_ERR;
						endcase
					end
				end
				B_STORE: begin
					if (is_last) state_q <= B_IDLE;
				end
				B_READ: state_q <= B_CAPT;
				B_CAPT: begin
					if (!pack_q && !is_last) begin
						pack_q  <= 1'b1;
						state_q <= B_READ;
					end else if (out_free) begin
						pack_q    <= 1'b0;
						state_q   <= is_last ? B_IDLE : B_READ;
					end
				end
				B_ERR: begin
					if (out_free) begin
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// command walk and payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= nxt;
			pos_q <= nxt.pos;
			k_q   <= 7'd0;
		end
		if (state_q == B_STORE) begin
			pos_q <= pos_q + PW'(1);
			k_q   <= k_q + 7'd1;
		end
		if (state_q == B_CAPT && !pack_q && !is_last) begin
			pk_r_q   <= cv_r;
			pk_g_q   <= cv_g;
			pk_b_q   <= cv_b;
			pk_col_q <= pos16[11:0];
			pos_q    <= pos_q + PW'(1);
			k_q      <= k_q + 7'd1;
		end
		if (emit) begin
			if (pack_q) begin
				first_red    <= pk_r_q;
				first_green  <= pk_g_q;
				first_blue   <= pk_b_q;
				second_red   <= cv_r;
				second_green <= cv_g;
				second_blue  <= cv_b;
				pixel_count  <= 2'd2;
				column       <= pk_col_q;
			end else begin
				first_red    <= cv_r;
				first_green  <= cv_g;
				first_blue   <= cv_b;
				second_red   <= 32'd0;
				second_green <= 32'd0;
				second_blue  <= 32'd0;
				pixel_count  <= 2'd1;
				column       <= pos16[11:0];
			end
			row_end       <= is_last && cur_q.row_end;
			image_end     <= is_last && cur_q.img_end;
			overrun_error <= 1'b0;
			last_of_item  <= is_last && cur_q.last;
			if (!is_last) begin
				pos_q <= pos_q + PW'(1);
				k_q   <= k_q + 7'd1;
			end
		end
		if (state_q == B_ERR && out_free) begin
			first_red     <= 32'd0;
			first_green   <= 32'd0;
			first_blue    <= 32'd0;
			second_red    <= 32'd0;
			second_green  <= 32'd0;
			second_blue   <= 32'd0;
			pixel_count   <= 2'd0;
			column        <= 12'd0;
			row_end       <= 1'b0;
			image_end     <= 1'b0;
			overrun_error <= 1'b1;
			last_of_item  <= cur_q.last;
		end
	end
endmodule
`default_nettype wire
